[hw/rtl/ssd_block_match_disparity_defines.svh]
// assertion helpers used by the checker
`ifndef SSD_BLOCK_MATCH_DISPARITY_DEFINES_SVH
`define SSD_BLOCK_MATCH_DISPARITY_DEFINES_SVH

// same-cycle implication
`define SSD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SSD_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/ssd_pkg.sv]
`timescale 1ns / 1ps
package ssd_pkg;

    localparam int KERNEL_DEF     = 5;
    localparam int MAX_DISP_DEF   = 32;
    localparam int LINE_WIDTH_DEF = 2048;

    localparam int PIX_W      = 8;
    localparam int PIX_MAX    = 255;
    localparam int POS_W      = 11;
    localparam int POS_LIM    = 2048;
    localparam int DISP_W     = 5;
    localparam int COST_W     = 21;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 12;
    localparam int DIM_W      = 12;
    localparam int SMALL_W    = 6;

    localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DISP_IN_USE  = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BORDER       = 4'd3;

    localparam logic [DIM_W-1:0]   RST_IMAGE_WIDTH  = 12'd1242;
    localparam logic [DIM_W-1:0]   RST_IMAGE_HEIGHT = 12'd375;
    localparam logic [SMALL_W-1:0] RST_DISP_IN_USE  = 6'd30;
    localparam logic [SMALL_W-1:0] RST_BORDER       = 6'd17;

    typedef struct packed {
        logic             vld;
        logic             emit;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic             fend;
    } t_meta;

endpackage

[hw/rtl/ssd_min_tree.sv]
`timescale 1ns / 1ps
module ssd_min_tree
    import ssd_pkg::*;
#(
    parameter int NUM = MAX_DISP_DEF,
    parameter int CW  = COST_W,
    localparam int IW = $clog2(NUM)
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  t_meta                  i_meta,
    input  logic [NUM-1:0][CW-1:0] i_cost,
    input  logic [NUM-1:0]         i_ok,
    output t_meta                  o_meta,
    output logic [CW-1:0]          o_cost,
    output logic [IW-1:0]          o_idx
);

    localparam int NL = 1 << IW;

    logic [CW-1:0] r_cost [IW+1][NL];
    logic [IW-1:0] r_idx  [IW+1][NL];
    logic          r_ok   [IW+1][NL];
    t_meta         r_meta [IW+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int l = 0; l <= IW; l++) begin
                r_meta[l].vld <= 1'b0;
            end
        end else if (i_en) begin
            r_meta[0] <= i_meta;
            for (int l = 1; l <= IW; l++) begin
                r_meta[l] <= r_meta[l-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int n = 0; n < NL; n++) begin
                r_idx[0][n] <= IW'(n);
                if (n < NUM) begin
                    r_cost[0][n] <= i_cost[n];
                    r_ok[0][n]   <= i_ok[n];
                end else begin
                    r_cost[0][n] <= '0;
                    r_ok[0][n]   <= 1'b0;
                end
            end
            for (int l = 1; l <= IW; l++) begin
                for (int n = 0; n < (NL >> l); n++) begin
                    // lower index wins ties
                    if (r_ok[l-1][2*n] && (!r_ok[l-1][2*n+1] ||
                            r_cost[l-1][2*n] <= r_cost[l-1][2*n+1])) begin
                        r_cost[l][n] <= r_cost[l-1][2*n];
                        r_idx[l][n]  <= r_idx[l-1][2*n];
                        r_ok[l][n]   <= r_ok[l-1][2*n];
                    end else begin
                        r_cost[l][n] <= r_cost[l-1][2*n+1];
                        r_idx[l][n]  <= r_idx[l-1][2*n+1];
                        r_ok[l][n]   <= r_ok[l-1][2*n+1];
                    end
                end
            end
        end
    end

    assign o_meta = r_meta[IW];
    assign o_cost = r_cost[IW][0];
    assign o_idx  = r_idx[IW][0];

endmodule

[hw/rtl/ssd_block_match_disparity.sv]
`timescale 1ns / 1ps
// channel   direction  handshake             payload
// cfg       in         i_cfg_valid/o_cfg_ready  i_cfg_index, i_cfg_data
// pixel     in         i_valid/o_stall       i_left_pixel, i_right_pixel, i_frame_start
// result    out        o_valid/i_stall       o_out_row, o_out_column, o_best_disparity,
//                                            o_best_cost, o_frame_end
// one pixel pair per cycle while o_stall is low
// the column store is read, patched and written back once per pixel (one port each)
// reset clears counters, pipeline valids and cost sums; store contents stay as they are
// a stalled result is held in the output register, the next one in a skid register
// o_stall rises only while the skid register is full
module ssd_block_match_disparity
    import ssd_pkg::*;
#(
    parameter int KERNEL     = KERNEL_DEF,
    parameter int MAX_DISP   = MAX_DISP_DEF,
    parameter int LINE_WIDTH = LINE_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [PIX_W-1:0]      i_left_pixel,
    input  logic [PIX_W-1:0]      i_right_pixel,
    input  logic                  i_frame_start,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [POS_W-1:0]      o_out_row,
    output logic [POS_W-1:0]      o_out_column,
    output logic [DISP_W-1:0]     o_best_disparity,
    output logic [COST_W-1:0]     o_best_cost,
    output logic                  o_frame_end
);

    localparam int HALF = KERNEL / 2;
    localparam int WIN  = 2 * HALF + 1;
    localparam int SLW  = $clog2(WIN);
    localparam int LAW  = $clog2(LINE_WIDTH);
    localparam int WLIM = (LINE_WIDTH < POS_LIM) ? LINE_WIDTH : POS_LIM;
    localparam int DEW  = $clog2(MAX_DISP + 1);
    localparam int KW   = $clog2(MAX_DISP);
    localparam int SQW  = 2 * PIX_W;
    localparam int CCW  = $clog2(WIN * PIX_MAX * PIX_MAX + 1);
    localparam int CW   = $clog2(WIN * WIN * PIX_MAX * PIX_MAX + 1);
    localparam int SW   = 14;
    localparam logic SIDE_LEFT  = 1'b0;
    localparam logic SIDE_RIGHT = 1'b1;

    typedef logic [1:0][WIN-1:0][PIX_W-1:0] t_word;
    typedef logic [WIN-1:0][PIX_W-1:0]      t_col;

    // configuration
    logic [DIM_W-1:0]   r_cfg_w, r_cfg_h;
    logic [SMALL_W-1:0] r_cfg_d, r_cfg_m;
    logic [DIM_W-1:0]   w_eff, h_eff;
    logic [DEW-1:0]     d_eff;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= RST_IMAGE_WIDTH;
            r_cfg_h <= RST_IMAGE_HEIGHT;
            r_cfg_d <= RST_DISP_IN_USE;
            r_cfg_m <= RST_BORDER;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_IMAGE_WIDTH:  r_cfg_w <= i_cfg_data;
                REG_IMAGE_HEIGHT: r_cfg_h <= i_cfg_data;
                REG_DISP_IN_USE:  r_cfg_d <= i_cfg_data[SMALL_W-1:0];
                REG_BORDER:       r_cfg_m <= i_cfg_data[SMALL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_cfg_w == '0) begin
            w_eff = DIM_W'(1);
        end else if (r_cfg_w > DIM_W'(WLIM)) begin
            w_eff = DIM_W'(WLIM);
        end else begin
            w_eff = r_cfg_w;
        end
        if (r_cfg_h == '0) begin
            h_eff = DIM_W'(1);
        end else if (r_cfg_h > DIM_W'(POS_LIM)) begin
            h_eff = DIM_W'(POS_LIM);
        end else begin
            h_eff = r_cfg_h;
        end
        if (r_cfg_d == '0) begin
            d_eff = DEW'(1);
        end else if (32'(r_cfg_d) > 32'(MAX_DISP)) begin
            d_eff = DEW'(MAX_DISP);
        end else begin
            d_eff = DEW'(r_cfg_d);
        end
    end

    // pipeline control
    logic r_skid_valid;
    logic en, accept;

    assign en      = !r_skid_valid;
    assign accept  = i_valid && en;
    assign o_stall = r_skid_valid;

    // raster position
    logic [POS_W-1:0] r_row, r_col;
    logic [SLW-1:0]   r_slot;
    logic [DIM_W-1:0] pos_row, pos_col, n_row, n_col;
    logic [SLW-1:0]   pos_slot, n_slot;

    always_comb begin
        pos_row  = {1'b0, r_row};
        pos_col  = {1'b0, r_col};
        pos_slot = r_slot;
        if (i_frame_start) begin
            pos_row  = '0;
            pos_col  = '0;
            pos_slot = '0;
        end
        if (pos_col >= w_eff) begin
            pos_col  = '0;
            pos_row  = pos_row + 1'b1;
            pos_slot = (pos_slot == SLW'(WIN - 1)) ? '0 : pos_slot + 1'b1;
        end
        if (pos_row >= h_eff) begin
            pos_row  = '0;
            pos_slot = '0;
        end
        n_row  = pos_row;
        n_col  = pos_col + 1'b1;
        n_slot = pos_slot;
        if (n_col >= w_eff) begin
            n_col  = '0;
            n_row  = pos_row + 1'b1;
            n_slot = (pos_slot == SLW'(WIN - 1)) ? '0 : pos_slot + 1'b1;
            if (n_row >= h_eff) begin
                n_row  = '0;
                n_slot = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row  <= '0;
            r_col  <= '0;
            r_slot <= '0;
        end else if (accept) begin
            r_row  <= n_row[POS_W-1:0];
            r_col  <= n_col[POS_W-1:0];
            r_slot <= n_slot;
        end
    end

    // center of the finished window and its border test
    logic signed [SW-1:0] s_y, s_x, s_half, s_m, s_w, s_h, s_d, s_r, s_c;
    t_meta                n_meta;

    always_comb begin
        s_y    = SW'(pos_row);
        s_x    = SW'(pos_col);
        s_half = SW'(HALF);
        s_m    = SW'(r_cfg_m);
        s_w    = SW'(w_eff);
        s_h    = SW'(h_eff);
        s_d    = SW'(d_eff);
        s_r    = s_y - s_half;
        s_c    = s_x - s_half - (s_d - SW'(1));
        n_meta.vld  = accept;
        n_meta.emit = (s_r >= s_m) && (s_r >= s_half) && (s_r < s_h - s_m) &&
                      (s_c >= s_m) && (s_c >= s_half) && (s_c < s_w - s_m - s_d);
        n_meta.row  = s_r[POS_W-1:0];
        n_meta.col  = s_c[POS_W-1:0];
        n_meta.fend = (s_r == s_h - s_m - SW'(1)) && (s_c == s_w - s_m - s_d - SW'(1));
    end

    // column store: one word holds all line slots of one column, both images
    t_word           mem [LINE_WIDTH];
    t_word           rd_word, cur_word, new_word, r_fwd_word;
    logic            r_fwd;
    logic [LAW-1:0]  pos_addr, r_addr1;
    logic [SLW-1:0]  r_slot1;
    logic [PIX_W-1:0] r_lpix1, r_rpix1;
    t_meta           r_m [5];

    assign pos_addr = LAW'(pos_col);

    always_ff @(posedge i_clk) begin
        if (en) begin
            rd_word <= mem[pos_addr];
        end
        if (en && r_m[0].vld) begin
            mem[r_addr1] <= new_word;
        end
    end

    always_comb begin
        cur_word = r_fwd ? r_fwd_word : rd_word;
        new_word = cur_word;
        new_word[SIDE_LEFT][r_slot1]  = r_lpix1;
        new_word[SIDE_RIGHT][r_slot1] = r_rpix1;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_addr1    <= pos_addr;
            r_slot1    <= pos_slot;
            r_lpix1    <= i_left_pixel;
            r_rpix1    <= i_right_pixel;
            r_fwd_word <= new_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd <= 1'b0;
            for (int k = 0; k < 5; k++) begin
                r_m[k].vld <= 1'b0;
            end
        end else if (en) begin
            // same column back to back: take the word being written
            r_fwd <= r_m[0].vld && accept && (pos_addr == r_addr1);
            r_m[0] <= n_meta;
            for (int k = 1; k < 5; k++) begin
                r_m[k] <= r_m[k-1];
            end
        end
    end

    // left columns of the last MAX_DISP pixels, right column of the newest
    t_col r_line [MAX_DISP];
    t_col r_rcol;

    always_ff @(posedge i_clk) begin
        if (en && r_m[0].vld) begin
            r_line[0] <= new_word[SIDE_LEFT];
            for (int k = 1; k < MAX_DISP; k++) begin
                r_line[k] <= r_line[k-1];
            end
            r_rcol <= new_word[SIDE_RIGHT];
        end
    end

    // squared differences, then column cost per disparity
    logic [SQW-1:0] r_sq [MAX_DISP][WIN];
    logic [PIX_W-1:0] ad [MAX_DISP][WIN];
    logic [CCW-1:0] cc_sum [MAX_DISP];
    logic [CCW-1:0] r_cc [MAX_DISP];

    always_comb begin
        for (int d = 0; d < MAX_DISP; d++) begin
            for (int s = 0; s < WIN; s++) begin
                ad[d][s] = (r_line[d][s] >= r_rcol[s]) ? r_line[d][s] - r_rcol[s]
                                                       : r_rcol[s] - r_line[d][s];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int d = 0; d < MAX_DISP; d++) begin
                for (int s = 0; s < WIN; s++) begin
                    r_sq[d][s] <= {{PIX_W{1'b0}}, ad[d][s]} * {{PIX_W{1'b0}}, ad[d][s]};
                end
            end
        end
    end

    always_comb begin
        for (int d = 0; d < MAX_DISP; d++) begin
            cc_sum[d] = '0;
            for (int s = 0; s < WIN; s++) begin
                cc_sum[d] = cc_sum[d] + CCW'(r_sq[d][s]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_cc <= cc_sum;
        end
    end

    // sliding window sums and their recent history per disparity
    logic [CCW-1:0] r_cdel [MAX_DISP][WIN];
    logic [CW-1:0]  r_hist [MAX_DISP][MAX_DISP];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int d = 0; d < MAX_DISP; d++) begin
                r_hist[d][0] <= '0;
                for (int k = 0; k < WIN; k++) begin
                    r_cdel[d][k] <= '0;
                end
            end
        end else if (en && r_m[3].vld) begin
            for (int d = 0; d < MAX_DISP; d++) begin
                r_hist[d][0] <= r_hist[d][0] + CW'(r_cc[d]) - CW'(r_cdel[d][WIN-1]);
                r_cdel[d][0] <= r_cc[d];
                for (int k = 1; k < WIN; k++) begin
                    r_cdel[d][k] <= r_cdel[d][k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && r_m[3].vld) begin
            for (int d = 0; d < MAX_DISP; d++) begin
                for (int k = 1; k < MAX_DISP; k++) begin
                    r_hist[d][k] <= r_hist[d][k-1];
                end
            end
        end
    end

    // disparity d sees the window that ended D-1-d pixels ago
    logic [MAX_DISP-1:0][CW-1:0] leaf_cost;
    logic [MAX_DISP-1:0]         leaf_ok;
    logic [DEW-1:0]              tap [MAX_DISP];

    always_comb begin
        for (int d = 0; d < MAX_DISP; d++) begin
            leaf_ok[d] = DEW'(d) < d_eff;
            tap[d]     = d_eff - DEW'(1) - DEW'(d);
            leaf_cost[d] = leaf_ok[d] ? r_hist[d][KW'(tap[d])] : '0;
        end
    end

    t_meta           tree_meta;
    logic [CW-1:0]   tree_cost;
    logic [KW-1:0]   tree_idx;

    ssd_min_tree #(
        .NUM (MAX_DISP),
        .CW  (CW)
    ) u_min_tree (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_meta  (r_m[4]),
        .i_cost  (leaf_cost),
        .i_ok    (leaf_ok),
        .o_meta  (tree_meta),
        .o_cost  (tree_cost),
        .o_idx   (tree_idx)
    );

    // output register and skid register
    logic              res_v;
    logic [COST_W-1:0] res_cost;
    logic              r_out_valid;
    logic [POS_W-1:0]  r_out_row, r_out_col, r_skid_row, r_skid_col;
    logic [DISP_W-1:0] r_out_disp, r_skid_disp;
    logic [COST_W-1:0] r_out_cost, r_skid_cost;
    logic              r_out_fend, r_skid_fend;

    assign res_v    = en && tree_meta.vld && tree_meta.emit;
    assign res_cost = (32'(tree_cost) > 32'(COST_MAX)) ? COST_MAX : COST_W'(tree_cost);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || !i_stall) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= res_v;
            end
        end else if (res_v) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || !i_stall) begin
            if (r_skid_valid) begin
                r_out_row  <= r_skid_row;
                r_out_col  <= r_skid_col;
                r_out_disp <= r_skid_disp;
                r_out_cost <= r_skid_cost;
                r_out_fend <= r_skid_fend;
            end else begin
                r_out_row  <= tree_meta.row;
                r_out_col  <= tree_meta.col;
                r_out_disp <= DISP_W'(tree_idx);
                r_out_cost <= res_cost;
                r_out_fend <= tree_meta.fend;
            end
        end else if (res_v) begin
            r_skid_row  <= tree_meta.row;
            r_skid_col  <= tree_meta.col;
            r_skid_disp <= DISP_W'(tree_idx);
            r_skid_cost <= res_cost;
            r_skid_fend <= tree_meta.fend;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_out_row        = r_out_row;
    assign o_out_column     = r_out_col;
    assign o_best_disparity = r_out_disp;
    assign o_best_cost      = r_out_cost;
    assign o_frame_end      = r_out_fend;

endmodule

[hw/rtl/ssd_checker.sv]
`timescale 1ns / 1ps
`include "ssd_block_match_disparity_defines.svh"
module ssd_checker
    import ssd_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_stall,
    input logic              o_valid,
    input logic              i_stall,
    input logic [POS_W-1:0]  o_out_column,
    input logic [COST_W-1:0] o_best_cost
);

    `SSD_ASSERT_NXT(a_result_held, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_best_cost) && $stable(o_out_column), "stalled result changed")
    `SSD_ASSERT_IMP(a_stall_needs_result, i_clk, i_rst_n, o_stall, o_valid, "input stalled with no result waiting")
    `SSD_ASSERT_IMP(a_stall_cause, i_clk, i_rst_n, o_stall && !$past(o_stall), $past(o_valid) && $past(i_stall), "input stall without output stall")

endmodule

bind ssd_block_match_disparity ssd_checker u_ssd_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_stall      (o_stall),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_out_column (o_out_column),
    .o_best_cost  (o_best_cost)
);

[verif/tb_ssd_block_match_disparity.sv]
`timescale 1ns / 1ps
module tb_ssd_block_match_disparity;
    import ssd_pkg::*;

    localparam int HALF_K = KERNEL_DEF / 2;
    localparam int WIN_ROWS = 2 * HALF_K + 1;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 4'hF;

    typedef struct {
        logic [PIX_W-1:0] left;
        logic [PIX_W-1:0] right;
        logic             fstart;
    } pixel_pair_t;

    typedef struct {
        logic [POS_W-1:0]  row;
        logic [POS_W-1:0]  col;
        logic [DISP_W-1:0] disp;
        logic [COST_W-1:0] cost;
        logic              fend;
    } disparity_t;

    typedef enum int {PIX_RANDOM, PIX_FLAT, PIX_EXTREME} pix_mode_e;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_valid = 1'b0;
    logic                  o_stall;
    logic [PIX_W-1:0]      i_left_pixel = '0;
    logic [PIX_W-1:0]      i_right_pixel = '0;
    logic                  i_frame_start = 1'b0;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    logic [POS_W-1:0]      o_out_row;
    logic [POS_W-1:0]      o_out_column;
    logic [DISP_W-1:0]     o_best_disparity;
    logic [COST_W-1:0]     o_best_cost;
    logic                  o_frame_end;

    ssd_block_match_disparity uut (.*);

    always #4 i_clk = ~i_clk;

    // predictor state
    logic [PIX_W-1:0] left_lines[WIN_ROWS][LINE_WIDTH_DEF];
    logic [PIX_W-1:0] right_lines[WIN_ROWS][LINE_WIDTH_DEF];
    int unsigned      row_pos = 0;
    int unsigned      col_pos = 0;
    logic [DIM_W-1:0]   cfg_width  = RST_IMAGE_WIDTH;
    logic [DIM_W-1:0]   cfg_height = RST_IMAGE_HEIGHT;
    logic [SMALL_W-1:0] cfg_disp   = RST_DISP_IN_USE;
    logic [SMALL_W-1:0] cfg_border = RST_BORDER;

    pixel_pair_t pending_pixels[$];
    disparity_t  expected_disparities[$];
    int          error_count = 0;
    int          result_count = 0;
    bit          quiet_tx = 1'b0;
    bit          quiet_rx = 1'b0;

    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 65) return 0;
        if (p < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int unsigned window_ssd(int r, int c, int d);
        int unsigned sum;
        int a;
        int b;
        sum = 0;
        for (int u = -HALF_K; u <= HALF_K; u++) begin
            for (int v = -HALF_K; v <= HALF_K; v++) begin
                a = left_lines[(r + u) % WIN_ROWS][c + v];
                b = right_lines[(r + u) % WIN_ROWS][c + v + d];
                sum += (a - b) * (a - b);
            end
        end
        return sum;
    endfunction

    task automatic predict_disparity(input pixel_pair_t px);
        int w, h, nd, m, y, x, r, c;
        int unsigned best, cost, bestd;
        disparity_t res;
        w = (cfg_width == 0) ? 1 : (cfg_width > 2048 ? 2048 : int'(cfg_width));
        h = (cfg_height == 0) ? 1 : (cfg_height > 2048 ? 2048 : int'(cfg_height));
        nd = (cfg_disp == 0) ? 1 : (cfg_disp > MAX_DISP_DEF ? MAX_DISP_DEF : int'(cfg_disp));
        m = cfg_border;
        if (px.fstart) begin
            row_pos = 0;
            col_pos = 0;
        end
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
        end
        if (row_pos >= h) row_pos = 0;
        y = row_pos;
        x = col_pos;
        left_lines[y % WIN_ROWS][x] = px.left;
        right_lines[y % WIN_ROWS][x] = px.right;
        r = y - HALF_K;
        c = x - HALF_K - (nd - 1);
        if (r >= m && r >= HALF_K && r < h - m && c >= m && c >= HALF_K && c < w - m - nd) begin
            best = 0;
            bestd = 0;
            for (int d = 0; d < nd; d++) begin
                cost = window_ssd(r, c, d);
                if (d == 0 || cost < best) begin
                    best = cost;
                    bestd = d;
                end
            end
            res.row = r;
            res.col = c;
            res.disp = bestd;
            res.cost = (best > COST_MAX) ? COST_MAX : best;
            res.fend = (r == h - m - 1 && c == w - m - nd - 1);
            expected_disparities.push_back(res);
        end
        col_pos++;
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
            if (row_pos >= h) row_pos = 0;
        end
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // pixel driver
    int tx_gap = 0;
    always @(posedge i_clk) begin
        pixel_pair_t px;
        bit take;
        if (i_rst_n) begin
            take = !i_valid;
            if (i_valid && !o_stall) begin
                predict_disparity('{i_left_pixel, i_right_pixel, i_frame_start});
                take = 1'b1;
                tx_gap = quiet_tx ? 0 : pick_gap();
            end
            if (take) begin
                if (tx_gap > 0 || pending_pixels.size() == 0) begin
                    if (tx_gap > 0) tx_gap--;
                    i_valid <= 1'b0;
                end else begin
                    px = pending_pixels.pop_front();
                    i_left_pixel <= px.left;
                    i_right_pixel <= px.right;
                    i_frame_start <= px.fstart;
                    i_valid <= 1'b1;
                end
            end
        end
    end

    // result monitor
    int rx_gap = 0;
    always @(posedge i_clk) begin
        disparity_t want;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                result_count++;
                if (expected_disparities.size() == 0) begin
                    report_mismatch("unexpected transfer, row", o_out_row, -1);
                end else begin
                    want = expected_disparities.pop_front();
                    if (o_out_row !== want.row) report_mismatch("row", o_out_row, want.row);
                    if (o_out_column !== want.col)
                        report_mismatch("column", o_out_column, want.col);
                    if (o_best_disparity !== want.disp)
                        report_mismatch("disparity", o_best_disparity, want.disp);
                    if (o_best_cost !== want.cost)
                        report_mismatch("cost", o_best_cost, want.cost);
                    if (o_frame_end !== want.fend)
                        report_mismatch("frame_end", o_frame_end, want.fend);
                end
            end
            if (quiet_rx) begin
                i_stall <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap--;
                i_stall <= 1'b1;
            end else begin
                rx_gap = pick_gap();
                i_stall <= (rx_gap > 0);
            end
        end
    end

    task automatic wait_drained();
        while (pending_pixels.size() != 0 || i_valid || expected_disparities.size() != 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        i_cfg_index <= idx;
        i_cfg_data <= val;
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            REG_IMAGE_WIDTH:  cfg_width = val;
            REG_IMAGE_HEIGHT: cfg_height = val;
            REG_DISP_IN_USE:  cfg_disp = val[SMALL_W-1:0];
            REG_BORDER:       cfg_border = val[SMALL_W-1:0];
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
    endtask

    task automatic configure(input int w, input int h, input int nd, input int m);
        wait_drained();
        write_reg(REG_IMAGE_WIDTH, w);
        write_reg(REG_IMAGE_HEIGHT, h);
        write_reg(REG_DISP_IN_USE, nd);
        write_reg(REG_BORDER, m);
    endtask

    task automatic queue_pixels(input int count, input pix_mode_e mode, input int noise);
        pixel_pair_t px;
        for (int k = 0; k < count; k++) begin
            case (mode)
                PIX_FLAT: begin
                    px.left = 8'd77;
                    px.right = 8'd77;
                end
                PIX_EXTREME: begin
                    px.left = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                    px.right = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                end
                default: begin
                    px.left = $urandom;
                    px.right = $urandom;
                end
            endcase
            px.fstart = (k == 0) || ($urandom_range(0, 999) < noise);
            pending_pixels.push_back(px);
        end
    endtask

    initial begin
        int w, h, nd, m, random_items;
        for (int k = 0; k < WIN_ROWS; k++)
            for (int j = 0; j < LINE_WIDTH_DEF; j++) begin
                left_lines[k][j] = '0;
                right_lines[k][j] = '0;
            end
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_reg(REG_UNUSED, 12'hABC);
        configure(12, 8, 1, 2);
        queue_pixels(96, PIX_FLAT, 0);
        queue_pixels(96, PIX_EXTREME, 0);
        configure(40, 7, 32, 2);
        queue_pixels(280, PIX_EXTREME, 0);
        configure(1, 2048, 5, 63);
        queue_pixels(30, PIX_RANDOM, 0);
        configure(2048, 6, 32, 2);
        queue_pixels(5 * 2048 + 60, PIX_RANDOM, 0);

        random_items = 0;
        while (random_items < 550 || result_count < 60) begin
            w = $urandom_range(12, 48);
            h = $urandom_range(6, 12);
            m = $urandom_range(2, 4);
            nd = $urandom_range(1, (w - 2 * m - 1 > 32) ? 32 : w - 2 * m - 1);
            configure(w, h, nd, m);
            quiet_tx = ($urandom_range(0, 3) == 0);
            quiet_rx = ($urandom_range(0, 3) == 0);
            queue_pixels(w * h + $urandom_range(0, w), PIX_RANDOM, $urandom_range(0, 1) ? 3 : 0);
            random_items += w * h;
        end
        wait_drained();

        if (error_count == 0) begin
            $display("** ssd_block_match_disparity: PASSED **");
        end else begin
            $display("** ssd_block_match_disparity: FAILED **");
        end
        $finish;
    end

    initial begin
        #10ms;
        $display("** ssd_block_match_disparity: FAILED **");
        $finish;
    end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/ssd_pkg.sv
hw/rtl/ssd_min_tree.sv
hw/rtl/ssd_block_match_disparity.sv
hw/rtl/ssd_checker.sv
verif/tb_ssd_block_match_disparity.sv
